// ===== rtl/kpl_pkg.sv =====
// Shared types, key codes, event codes and the keypad table for the keypad PIN lock.
package kpl_pkg;

    localparam int PIN_DIGITS = 4;
    localparam int CNT_W      = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam int NUM_ROWS   = 4;

    localparam logic [3:0] KEY_NONE = 4'd0;
    localparam logic [3:0] KEY_STAR = 4'd11;
    localparam logic [3:0] KEY_HASH = 4'd12;

    typedef enum logic [1:0] {
        MODE_SET      = 2'd0,
        MODE_LOCKED   = 2'd1,
        MODE_UNLOCKED = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STORED  = 3'd1,
        EV_ERASED  = 3'd2,
        EV_NEWPW   = 3'd3,
        EV_WRONG   = 3'd4,
        EV_CORRECT = 3'd5,
        EV_SET     = 3'd6
    } event_t;

    typedef struct packed {
        logic [2:0] row0_cols;
        logic [2:0] row1_cols;
        logic [2:0] row2_cols;
        logic [2:0] row3_cols;
    } scan_t;

    typedef struct packed {
        logic [3:0] new_key;
        logic [2:0] event_res;
        logic [1:0] lock_mode;
        logic [2:0] digits_entered;
    } result_t;

    typedef struct packed {
        logic       pressed;
        logic [3:0] key;
    } lane_hit_t;

    function automatic logic [3:0] key_code(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] code;
        code = KEY_NONE;
        case (row)
            2'd0: code = (col == 2'd0) ? 4'd2 : (col == 2'd1) ? 4'd3 : 4'd4;
            2'd1: code = (col == 2'd0) ? 4'd5 : (col == 2'd1) ? 4'd6 : 4'd7;
            2'd2: code = (col == 2'd0) ? 4'd8 : (col == 2'd1) ? 4'd9 : 4'd10;
            2'd3: code = (col == 2'd0) ? KEY_STAR : (col == 2'd1) ? 4'd1 : KEY_HASH;
            default: code = KEY_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] reset_pin_digit(input int k);
        return (k % 2 == 1) ? 4'd9 : 4'd4;
    endfunction

endpackage

// ===== rtl/keypad_pin_lock.sv =====
// Top level of the keypad PIN lock: row lanes, merge register and lock core.
//
//   Channel   Valid          Stall          Payload
//   scan      scan_valid     scan_stall     scan   (kpl_pkg::scan_t, one full keypad scan)
//   result    result_valid   result_stall   result (kpl_pkg::result_t, one per scan)
//
// Each scan beat passes through four row lanes and the merge, which feed a key register;
// the lock core then updates its state and result register when the beat moves on.
// One beat can be accepted every cycle while the result side is not stalling.
// Reset clears the key filter and digit count, sets the mode to locked and loads the default PIN.
// A stall on the result side holds both stages; the scan side stalls only when they are full.
module keypad_pin_lock (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             scan_valid,
    output logic             scan_stall,
    input  kpl_pkg::scan_t   scan,
    output logic             result_valid,
    input  logic             result_stall,
    output kpl_pkg::result_t result
);

    kpl_pkg::lane_hit_t hits [kpl_pkg::NUM_ROWS];
    logic [2:0]         row_cols [kpl_pkg::NUM_ROWS];
    logic [3:0]         merged_key;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [3:0] s1_key_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       s1_move;
    logic       scan_take;

    assign row_cols[0] = scan.row0_cols;
    assign row_cols[1] = scan.row1_cols;
    assign row_cols[2] = scan.row2_cols;
    assign row_cols[3] = scan.row3_cols;

    for (genvar r = 0; r < kpl_pkg::NUM_ROWS; r++)
    begin : g_lane
        kpl_row_lane u_lane (
            .row  (2'(r)),
            .cols (row_cols[r]),
            .hit  (hits[r])
        );
    end

    kpl_scan_merge u_merge (
        .hits (hits),
        .key  (merged_key)
    );

    assign s1_move        = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign scan_stall     = s1_valid_reg && !s1_move;
    assign scan_take      = scan_valid && !scan_stall;
    assign s1_valid_next  = scan_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            s1_key_reg <= merged_key;
        end
    end

    kpl_lock_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_move),
        .scan_key (s1_key_reg),
        .result   (result)
    );

    assign result_valid = out_valid_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("scan side stalled while the pipeline had room");

    a_move_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> result_valid)
        else $error("a moved beat did not reach the result register");

    a_none_key_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.new_key == kpl_pkg::KEY_NONE))
        |-> (result.event_res == kpl_pkg::EV_NONE))
        else $error("event reported without a new key");

    a_set_locks_and_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_res == kpl_pkg::EV_SET))
        |-> ((result.lock_mode == kpl_pkg::MODE_LOCKED) && (result.digits_entered == 3'd0)))
        else $error("new PIN stored without locking and clearing the entry");

endmodule

// ===== rtl/kpl_row_lane.sv =====
// One row lane: finds the lowest pressed column of a row and looks up its key code.
module kpl_row_lane (
    input  logic [1:0]         row,
    input  logic [2:0]         cols,
    output kpl_pkg::lane_hit_t hit
);

    always_comb
    begin
        hit.pressed = 1'b1;
        if (!cols[2])
        begin
            hit.key = kpl_pkg::key_code(row, 2'd0);
        end
        else if (!cols[1])
        begin
            hit.key = kpl_pkg::key_code(row, 2'd1);
        end
        else if (!cols[0])
        begin
            hit.key = kpl_pkg::key_code(row, 2'd2);
        end
        else
        begin
            hit.pressed = 1'b0;
            hit.key     = kpl_pkg::KEY_NONE;
        end
    end

endmodule

// ===== rtl/kpl_scan_merge.sv =====
// Merge stage: the highest-numbered row lane with a press supplies the scanned key.
module kpl_scan_merge (
    input  kpl_pkg::lane_hit_t hits [kpl_pkg::NUM_ROWS],
    output logic [3:0]         key
);

    always_comb
    begin
        key = kpl_pkg::KEY_NONE;
        for (int r = 0; r < kpl_pkg::NUM_ROWS; r++)
        begin
            if (hits[r].pressed)
            begin
                key = hits[r].key;
            end
        end
    end

endmodule

// ===== rtl/kpl_lock_core.sv =====
// Lock state: repeat filter, entry buffer, stored PIN, mode and the result register.
module kpl_lock_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [3:0]          scan_key,
    output kpl_pkg::result_t    result
);

    localparam int N = kpl_pkg::PIN_DIGITS;
    localparam int W = kpl_pkg::CNT_W;

    logic [3:0]       prev_key_reg;
    logic [W-1:0]     count_reg;
    logic [W-1:0]     count_next;
    kpl_pkg::mode_t   mode_reg;
    kpl_pkg::mode_t   mode_next;
    logic [3:0]       entry_reg [N];
    logic [3:0]       pin_reg   [N];
    logic [3:0]       pin_next  [N];
    kpl_pkg::result_t result_reg;
    kpl_pkg::result_t result_next;
    kpl_pkg::event_t  ev;

    logic [3:0] key;
    logic [3:0] digit;
    logic       is_digit;
    logic       full;
    logic       match;
    logic       write_entry;

    always_comb
    begin
        key      = (scan_key != prev_key_reg) ? scan_key : kpl_pkg::KEY_NONE;
        is_digit = (key != kpl_pkg::KEY_NONE) && (key != kpl_pkg::KEY_STAR)
                   && (key != kpl_pkg::KEY_HASH);
        digit    = key - 4'd1;
        full     = is_digit && (count_reg == W'(N - 1));
        match    = (digit == pin_reg[N-1]);
        for (int k = 0; k < N - 1; k++)
        begin
            if (entry_reg[k] != pin_reg[k])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (key == kpl_pkg::KEY_STAR)
        begin
            if (mode_reg == kpl_pkg::MODE_LOCKED)
            begin
                mode_next = kpl_pkg::MODE_SET;
            end
        end
        else if (full)
        begin
            case (mode_reg)
                kpl_pkg::MODE_SET:      mode_next = kpl_pkg::MODE_LOCKED;
                kpl_pkg::MODE_LOCKED:   mode_next = match ? kpl_pkg::MODE_UNLOCKED
                                                          : kpl_pkg::MODE_LOCKED;
                kpl_pkg::MODE_UNLOCKED: mode_next = match ? kpl_pkg::MODE_LOCKED
                                                          : kpl_pkg::MODE_UNLOCKED;
                default:                mode_next = match ? kpl_pkg::MODE_LOCKED : mode_reg;
            endcase
        end
    end

    always_comb
    begin
        ev          = kpl_pkg::EV_NONE;
        count_next  = count_reg;
        write_entry = 1'b0;
        for (int k = 0; k < N; k++)
        begin
            pin_next[k] = pin_reg[k];
        end
        if (key == kpl_pkg::KEY_HASH)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - W'(1);
                ev         = kpl_pkg::EV_ERASED;
            end
        end
        else if (key == kpl_pkg::KEY_STAR)
        begin
            if (mode_reg == kpl_pkg::MODE_LOCKED)
            begin
                count_next = '0;
                ev         = kpl_pkg::EV_NEWPW;
            end
        end
        else if (is_digit)
        begin
            if (full)
            begin
                count_next = '0;
                if (mode_reg != kpl_pkg::MODE_SET)
                begin
                    ev = match ? kpl_pkg::EV_CORRECT : kpl_pkg::EV_WRONG;
                end
                else
                begin
                    ev = kpl_pkg::EV_SET;
                    for (int k = 0; k < N - 1; k++)
                    begin
                        pin_next[k] = entry_reg[k];
                    end
                    pin_next[N-1] = digit;
                end
            end
            else
            begin
                write_entry = 1'b1;
                count_next  = count_reg + W'(1);
                ev          = kpl_pkg::EV_STORED;
            end
        end
        result_next.new_key        = key;
        result_next.event_res      = ev;
        result_next.lock_mode      = mode_next;
        result_next.digits_entered = 3'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg <= kpl_pkg::KEY_NONE;
            count_reg    <= '0;
            mode_reg     <= kpl_pkg::MODE_LOCKED;
            for (int k = 0; k < N; k++)
            begin
                pin_reg[k] <= kpl_pkg::reset_pin_digit(k);
            end
        end
        else if (step)
        begin
            prev_key_reg <= scan_key;
            count_reg    <= count_next;
            mode_reg     <= mode_next;
            for (int k = 0; k < N; k++)
            begin
                pin_reg[k] <= pin_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
            if (write_entry)
            begin
                entry_reg[count_reg] <= digit;
            end
        end
    end

    assign result = result_reg;

endmodule
